/* hdl/bmms_pkg.sv */
// ----------------------------------------------------------------------------
// bmms_pkg
// Shared types, constants and arithmetic helpers of the motor model step.
// ----------------------------------------------------------------------------
package bmms_pkg;

  // motor pole count
  localparam int unsigned POLES = 8;

  // register indexes of the configuration port
  localparam logic [2:0] REG_SUPPLY   = 3'd0;
  localparam logic [2:0] REG_EMF      = 3'd1;
  localparam logic [2:0] REG_RES      = 3'd2;
  localparam logic [2:0] REG_INV_L    = 3'd3;
  localparam logic [2:0] REG_INV_J    = 3'd4;
  localparam logic [2:0] REG_FR_STAT  = 3'd5;
  localparam logic [2:0] REG_FR_DYN   = 3'd6;
  localparam logic [2:0] REG_TSTEP    = 3'd7;

  // phase drive modes
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_LOW  = 2'd1;
  localparam logic [1:0] MODE_HIGH = 2'd2;
  localparam logic [1:0] MODE_PWM  = 2'd3;

  // angle and scaling constants
  localparam logic [15:0] TWO_THIRDS_TURN  = 16'd43691;
  localparam logic signed [31:0] STANDSTILL_SPEED = 32'sd66;
  localparam logic signed [35:0] INV_TWO_PI_Q24 = 36'sd2670177;
  localparam logic signed [35:0] RECIP_THREE    = 36'sd1431655765;

  // schedule of the shared multiplier, one operation a step
  localparam logic [4:0] STEP_LAST   = 5'd28;
  localparam logic [4:0] STEP_COMMIT = 5'd29;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_COMMIT
  } bmms_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       run;
    logic [4:0] step;
    logic       commit;
  } bmms_cmd_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
    logic signed [31:0] r;
    if (x > 72'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -72'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  // trapezoidal back emf shape, negated
  function automatic logic signed [17:0] emf_shape(input logic [15:0] a);
    logic [19:0] t;
    logic signed [17:0] f;
    t = 20'(a) * 20'd12;
    if (t < 20'd65536) f = $signed({2'b00, t[15:0]});
    else if (t < 20'd327680) f = 18'sd65536;
    else if (t < 20'd458752) f = ($signed({2'b00, 16'h8000}) - $signed({2'b00, a})) * 18'sd12;
    else if (t < 20'd720896) f = -18'sd65536;
    else f = ($signed({2'b00, a}) - 18'sd65536) * 18'sd12;
    return -f;
  endfunction

  // hall sensor bits of a sector index
  function automatic logic [2:0] hall_bits(input logic [2:0] idx);
    logic [2:0] h;
    case (idx)
      3'd0:    h = 3'b001;
      3'd1:    h = 3'b011;
      3'd2:    h = 3'b010;
      3'd3:    h = 3'b110;
      3'd4:    h = 3'b100;
      3'd5:    h = 3'b101;
      default: h = 3'b000;
    endcase
    return h;
  endfunction

endpackage

/* hdl/bmms_ctrl.sv */
// ----------------------------------------------------------------------------
// bmms_ctrl
// Sequencer of the motor model step: accepts a word, walks the multiplier
// schedule and hands the result to the output register.
// ----------------------------------------------------------------------------
module bmms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output bmms_pkg::bmms_cmd_t cmd
);
  import bmms_pkg::*;

  bmms_state_t state_r, state_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_tvalid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_COMMIT;
          step_nxt  = STEP_COMMIT;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      ST_COMMIT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready     = (state_r == ST_IDLE);
    cmd.load      = in_tvalid && (state_r == ST_IDLE);
    cmd.run       = (state_r == ST_RUN);
    cmd.step      = step_r;
    cmd.commit    = (state_r == ST_COMMIT) && slot_free;
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.commit) out_valid_nxt = 1'b1;
    out_tvalid    = out_valid_r;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/bmms_dp.sv */
// ----------------------------------------------------------------------------
// bmms_dp
// Datapath of the motor model step: configuration, motor state, one shared
// registered multiplier and the result register.
// ----------------------------------------------------------------------------
module bmms_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  bmms_pkg::bmms_cmd_t cmd,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [119:0]        in_tdata,
  output logic [295:0]        out_tdata
);
  import bmms_pkg::*;

  // configuration
  logic [30:0] vbus_r, ke_r, res_r, invl_r, invj_r, fstat_r, fdyn_r;
  logic [31:0] ts_r;

  // latched input word
  logic [1:0]         mode_r [3];
  logic [15:0]        duty_r [3];
  logic signed [31:0] limit_r, load_r;

  // motor state
  logic signed [31:0] cur_r [3];
  logic signed [31:0] speed_r;
  logic [15:0]        mech_st_r, elec_st_r;

  // intermediates
  logic signed [71:0] p_r;
  logic signed [31:0] keo_r, tf_r, te_r, dom_r, wnew_r, center_r;
  logic signed [31:0] pot_r [3];
  logic signed [31:0] ri_r [3];
  logic signed [31:0] e_r [3];
  logic signed [31:0] d2_r [3];
  logic signed [31:0] inew_r [3];
  logic signed [51:0] dot_r;
  logic signed [40:0] x_r;
  logic [23:0]        th_r;
  logic [15:0]        mech_r;
  logic [33:0]        nabs_r, q0_r;
  logic [1:0]         cnt_r;
  logic               neg_r;
  logic [295:0]       out_data_r;

  logic signed [35:0] ma, mb;
  logic [15:0]        ang [3];
  logic signed [17:0] shape [3];
  logic [1:0]         mode_eff [3];
  logic signed [31:0] pot [3];
  logic signed [31:0] v [3];
  logic signed [31:0] dsat [3];
  logic signed [34:0] sum;
  logic [1:0]         cnt;
  logic [33:0]        n_abs;
  logic signed [31:0] coef, tm, w0, center_c;
  logic signed [32:0] diff;
  logic [47:0]        turn_sum;
  logic [35:0]        rem3;
  logic [33:0]        q3, mag;
  logic [22:0]        elec_full;
  logic [15:0]        elec;
  logic [18:0]        sect_full;
  logic [2:0]         sect;

  // phase angles, shapes, effective modes and potentials
  always_comb begin
    ang[0] = elec_st_r;
    ang[1] = elec_st_r + TWO_THIRDS_TURN;
    ang[2] = ang[1] + TWO_THIRDS_TURN;
    sum = '0;
    cnt = '0;
    for (int i = 0; i < 3; i++) begin
      shape[i]    = emf_shape(ang[i]);
      mode_eff[i] = mode_r[i];
      if (!limit_r[31] && mode_r[i][1] && (cur_r[i] > limit_r)) mode_eff[i] = MODE_LOW;
      case (mode_eff[i])
        MODE_HIGH: pot[i] = $signed({1'b0, vbus_r});
        MODE_PWM:  pot[i] = pot_r[i];
        default:   pot[i] = '0;
      endcase
      if (mode_eff[i] != MODE_OFF) begin
        sum = sum + 35'(pot[i]) - 35'(e_r[i]);
        cnt = cnt + 2'd1;
      end
      v[i]    = (mode_eff[i] == MODE_OFF) ? e_r[i] : sat32(72'(pot[i]) - 72'(center_r));
      dsat[i] = sat32(72'(v[i]) - 72'(ri_r[i]) - 72'(e_r[i]));
    end
    n_abs = sum[34] ? 34'(-sum) : sum[33:0];
  end

  // neutral: divide by the driven phase count, toward zero
  always_comb begin
    rem3 = {2'b00, nabs_r} - ({2'b00, q0_r} + {1'b0, q0_r, 1'b0});
    q3   = q0_r + 34'(rem3 >= 36'd3) + 34'(rem3 >= 36'd6);
    case (cnt_r)
      2'd1:    mag = nabs_r;
      2'd2:    mag = nabs_r >> 1;
      2'd3:    mag = q3;
      default: mag = '0;
    endcase
    center_c = neg_r ? sat32(-72'($signed({1'b0, mag}))) : sat32(72'($signed({1'b0, mag})));
  end

  // mechanics
  always_comb begin
    coef = ((speed_r < STANDSTILL_SPEED) && (speed_r > -STANDSTILL_SPEED)) ?
           $signed({1'b0, fstat_r}) : $signed({1'b0, fdyn_r});
    tm   = sat32(72'(te_r) - 72'(load_r) - 72'(tf_r));
    diff = 33'(te_r) - 33'(load_r);
    w0   = sat32(72'(speed_r) + 72'(sat32(p_r >>> 32)));
    turn_sum = {th_r, 24'd0} + p_r[47:0];
  end

  // angles and hall code of the new position
  always_comb begin
    elec_full = 23'(mech_r) * 23'(POLES);
    elec      = elec_full[16:1];
    sect_full = 19'(elec) * 19'd6 + 19'd32768;
    sect      = (sect_full[18:16] == 3'd6) ? 3'd0 : sect_full[18:16];
  end

  // operand select of the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.step)
      5'd0:  begin ma = $signed({5'd0, ke_r});  mb = 36'(speed_r); end
      5'd1:  begin ma = $signed({5'd0, vbus_r}); mb = $signed({20'd0, duty_r[0]}); end
      5'd2:  begin ma = $signed({5'd0, vbus_r}); mb = $signed({20'd0, duty_r[1]}); end
      5'd3:  begin ma = $signed({5'd0, vbus_r}); mb = $signed({20'd0, duty_r[2]}); end
      5'd4:  begin ma = 36'(shape[0]); mb = 36'(cur_r[0]); end
      5'd5:  begin ma = 36'(shape[1]); mb = 36'(cur_r[1]); end
      5'd6:  begin ma = 36'(shape[2]); mb = 36'(cur_r[2]); end
      5'd7:  begin ma = $signed({5'd0, res_r}); mb = 36'(cur_r[0]); end
      5'd8:  begin ma = $signed({5'd0, res_r}); mb = 36'(cur_r[1]); end
      5'd9:  begin ma = $signed({5'd0, res_r}); mb = 36'(cur_r[2]); end
      5'd10: begin ma = 36'(speed_r); mb = $signed({4'd0, ts_r}); end
      5'd11: begin ma = 36'(shape[0]); mb = 36'(keo_r); end
      5'd12: begin ma = 36'(shape[1]); mb = 36'(keo_r); end
      5'd13: begin ma = 36'(shape[2]); mb = 36'(keo_r); end
      5'd14: begin ma = 36'(coef); mb = 36'(speed_r); end
      5'd15: begin ma = 36'(sat32(72'(dot_r) >>> 16)); mb = $signed({5'd0, ke_r}); end
      5'd16: begin ma = 36'($signed(x_r[40:24])); mb = INV_TWO_PI_Q24; end
      5'd17: begin ma = $signed({12'd0, x_r[23:0]}); mb = INV_TWO_PI_Q24; end
      5'd18: begin ma = $signed({2'b00, n_abs}); mb = RECIP_THREE; end
      5'd19: begin ma = 36'(tm); mb = $signed({5'd0, invj_r}); end
      5'd21: begin ma = 36'(dom_r); mb = $signed({4'd0, ts_r}); end
      5'd22: begin ma = 36'(dsat[0]); mb = $signed({5'd0, invl_r}); end
      5'd23: begin ma = 36'(dsat[1]); mb = $signed({5'd0, invl_r}); end
      5'd24: begin ma = 36'(dsat[2]); mb = $signed({5'd0, invl_r}); end
      5'd25: begin ma = 36'(d2_r[0]); mb = $signed({4'd0, ts_r}); end
      5'd26: begin ma = 36'(d2_r[1]); mb = $signed({4'd0, ts_r}); end
      5'd27: begin ma = 36'(d2_r[2]); mb = $signed({4'd0, ts_r}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    p_r <= ma * mb;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbus_r  <= 31'd786432;
      ke_r    <= 31'd655;
      res_r   <= 31'd65536;
      invl_r  <= 31'd65536000;
      invj_r  <= 31'd65536000;
      fstat_r <= 31'd66;
      fdyn_r  <= 31'd66;
      ts_r    <= 32'd42950;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SUPPLY:  vbus_r  <= cfg_data[30:0];
        REG_EMF:     ke_r    <= cfg_data[30:0];
        REG_RES:     res_r   <= cfg_data[30:0];
        REG_INV_L:   invl_r  <= cfg_data[30:0];
        REG_INV_J:   invj_r  <= cfg_data[30:0];
        REG_FR_STAT: fstat_r <= cfg_data[30:0];
        REG_FR_DYN:  fdyn_r  <= cfg_data[30:0];
        REG_TSTEP:   ts_r    <= cfg_data;
        default:     ts_r    <= ts_r;
      endcase
    end
  end

  // input word latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r[0] <= in_tdata[1:0];
      mode_r[1] <= in_tdata[3:2];
      mode_r[2] <= in_tdata[5:4];
      duty_r[0] <= in_tdata[21:6];
      duty_r[1] <= in_tdata[37:22];
      duty_r[2] <= in_tdata[53:38];
      limit_r   <= in_tdata[85:54];
      load_r    <= in_tdata[117:86];
    end
  end

  // consume the product of the previous step
  always_ff @(posedge clk) begin
    if (cmd.run) begin
      case (cmd.step)
        5'd1:  keo_r <= sat32(p_r >>> 16);
        5'd2:  pot_r[0] <= sat32(p_r >>> 16);
        5'd3:  pot_r[1] <= sat32(p_r >>> 16);
        5'd4:  pot_r[2] <= sat32(p_r >>> 16);
        5'd5:  dot_r <= p_r[51:0];
        5'd6:  dot_r <= dot_r + p_r[51:0];
        5'd7:  dot_r <= dot_r + p_r[51:0];
        5'd8:  ri_r[0] <= sat32(p_r >>> 16);
        5'd9:  ri_r[1] <= sat32(p_r >>> 16);
        5'd10: ri_r[2] <= sat32(p_r >>> 16);
        5'd11: x_r <= 41'(p_r >>> 24);
        5'd12: e_r[0] <= sat32(p_r >>> 16);
        5'd13: e_r[1] <= sat32(p_r >>> 16);
        5'd14: e_r[2] <= sat32(p_r >>> 16);
        5'd15: tf_r <= sat32(p_r >>> 16);
        5'd16: te_r <= sat32(p_r >>> 16);
        5'd17: th_r <= p_r[23:0];
        5'd18: begin
          mech_r <= mech_st_r + turn_sum[47:32];
          nabs_r <= n_abs;
          neg_r  <= sum[34];
          cnt_r  <= cnt;
        end
        5'd19: q0_r <= p_r[65:32];
        5'd20: begin
          dom_r    <= sat32(p_r >>> 16);
          center_r <= center_c;
        end
        5'd22: begin
          if ((diff == 33'sd0) && ((w0 == 32'sd0) || (w0[31] != speed_r[31])))
            wnew_r <= '0;
          else
            wnew_r <= w0;
        end
        5'd23: d2_r[0] <= sat32(p_r >>> 16);
        5'd24: d2_r[1] <= sat32(p_r >>> 16);
        5'd25: d2_r[2] <= sat32(p_r >>> 16);
        5'd26: inew_r[0] <= sat32(72'(cur_r[0]) + 72'(sat32(p_r >>> 32)));
        5'd27: inew_r[1] <= sat32(72'(cur_r[1]) + 72'(sat32(p_r >>> 32)));
        5'd28: inew_r[2] <= sat32(72'(cur_r[2]) + 72'(sat32(p_r >>> 32)));
        default: th_r <= th_r;
      endcase
    end
  end

  // motor state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) cur_r[i] <= '0;
      speed_r   <= '0;
      mech_st_r <= '0;
      elec_st_r <= '0;
    end else if (cmd.commit) begin
      for (int i = 0; i < 3; i++) cur_r[i] <= inew_r[i];
      speed_r   <= wnew_r;
      mech_st_r <= mech_r;
      elec_st_r <= elec;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {5'd0, hall_bits(sect), te_r, elec, mech_r, wnew_r,
                     v[2], v[1], v[0], inew_r[2], inew_r[1], inew_r[0]};
    end
  end

  assign out_tdata = out_data_r;

endmodule

/* hdl/bldc_motor_model_step.sv */
// ----------------------------------------------------------------------------
// bldc_motor_model_step
// Trapezoidal back emf brushless motor model, one Euler step per input word.
// ----------------------------------------------------------------------------
// Each accepted input word advances the motor state by one tick and yields
// one result word. The step runs as a fixed schedule of 29 steps, 27 of which
// issue a product on a single shared registered multiplier, then a commit
// state writes the motor state and the result register. The next input word
// is taken in the cycle after the commit, so no new word is accepted while a
// tick is in progress. A waiting result stalls the block only at the end of
// the next tick.
// Configuration words may be written while the block is idle.
module bldc_motor_model_step (
  input  logic         clk,
  input  logic         rst_n,
  // config write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  // input word
  input  logic         in_tvalid,
  output logic         in_tready,
  // phase_a_mode[1:0], phase_b_mode[3:2], phase_c_mode[5:4], duty_a[21:6],
  // duty_b[37:22], duty_c[53:38], amp_limit[85:54], load_torque[117:86]
  input  logic [119:0] in_tdata,
  // result word
  output logic         out_tvalid,
  input  logic         out_tready,
  // current_a[31:0], current_b[63:32], current_c[95:64], voltage_a[127:96],
  // voltage_b[159:128], voltage_c[191:160], speed[223:192],
  // mech_angle[239:224], elec_angle[255:240], torque[287:256],
  // hall_code[290:288]
  output logic [295:0] out_tdata
);
  import bmms_pkg::*;

  bmms_cmd_t cmd;

  // registers are always writable
  assign cfg_ready = 1'b1;

  bmms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bmms_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
